[hw/rtl/svrm_pkg.sv]
// Shared types and constants for the sample voice resample mixer.
// Used by the top level and the phase divider; depends on nothing.
`timescale 1ns / 1ps

package svrm_pkg;

    // field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 8;
    localparam int RATE_W     = 18;
    localparam int SCALE_W    = 16;
    localparam int LEN_W      = 17;
    localparam int POS_W      = 17;
    localparam int PHASE_W    = 18;
    localparam int INCR_W     = 26;
    localparam int PE_W       = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // phase divider: three quotient bits per cycle
    localparam int DIV_STEPS  = 3;
    localparam int DIV_CYCLES = PE_W / DIV_STEPS;
    localparam int DIV_CNT_W  = 4;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // item modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_MIX     = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd6;

    // configuration reset values
    localparam logic [VOL_W-1:0]   VOLUME_RST      = 8'd128;
    localparam logic [RATE_W-1:0]  SOURCE_RATE_RST = 18'd48000;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 16'd256;
    localparam logic [RATE_W-1:0]  OUTPUT_RATE_RST = 18'd48000;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [15:0]                sample_address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic signed [SAMPLE_W-1:0] bus_left;
        logic signed [SAMPLE_W-1:0] bus_right;
    } svrm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
        logic                       voice_done;
    } svrm_out_t;

endpackage

[hw/rtl/svrm_div.sv]
// Iterative restoring divider for the phase carry: quotient and remainder.
// Depends on svrm_pkg for widths and step count.
`timescale 1ns / 1ps

module svrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [svrm_pkg::PE_W-1:0]    dividend,
    input  logic [svrm_pkg::PHASE_W-1:0] divisor,
    output logic                        done,
    output logic [svrm_pkg::PE_W-1:0]    quotient,
    output logic [svrm_pkg::PHASE_W-1:0] remainder
);

    logic [svrm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;
    logic [svrm_pkg::PE_W-1:0]      dq_reg;
    logic [svrm_pkg::PE_W-1:0]      dq_next;
    logic [svrm_pkg::PHASE_W-1:0]   rem_reg;
    logic [svrm_pkg::PHASE_W-1:0]   rem_next;
    logic [svrm_pkg::PHASE_W-1:0]   divisor_reg;
    logic [svrm_pkg::PHASE_W:0]     trial;

    // shift dividend bits out at the top, quotient bits in at the bottom
    always_comb
    begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < svrm_pkg::DIV_STEPS; i++)
        begin
            trial   = {rem_next, dq_next[svrm_pkg::PE_W-1]};
            dq_next = {dq_next[svrm_pkg::PE_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial      = trial - {1'b0, divisor_reg};
                dq_next[0] = 1'b1;
            end
            rem_next = trial[svrm_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= svrm_pkg::DIV_CNT_W'(svrm_pkg::DIV_CYCLES);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == svrm_pkg::DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg      <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/sample_voice_resample_mixer.sv]
// One playback voice mixed into a stereo bus; top level. Uses svrm_pkg, svrm_div.
// Write, restart and ended-voice items go from accept straight to PUSH; a mix
// passes RD_R, MIX and SAT, and with a phase carry also DIV (the phase divider).
// A new item is taken only in IDLE, once the last one has left PUSH. Async
// active-low reset clears position, phase, config and handshake; the sample
// store is not cleared and needs no sweep.
`timescale 1ns / 1ps

module sample_voice_resample_mixer #(
    parameter int STORE_WORDS = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [svrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svrm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  svrm_pkg::svrm_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output svrm_pkg::svrm_out_t               out_data
);

    localparam int AW    = $clog2(STORE_WORDS);
    // address arithmetic width: covers both the store and position + 1
    localparam int EXT_W = (AW > svrm_pkg::POS_W + 1) ? AW : svrm_pkg::POS_W + 1;
    localparam int SUM_W = svrm_pkg::PE_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_R,
        S_MIX,
        S_SAT,
        S_DIV,
        S_PUSH
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [svrm_pkg::VOL_W-1:0]   vol_reg;
    logic [svrm_pkg::RATE_W-1:0]  src_reg;
    logic [svrm_pkg::SCALE_W-1:0] scale_reg;
    logic [svrm_pkg::RATE_W-1:0]  orate_reg;
    logic                         stereo_reg;
    logic [svrm_pkg::LEN_W-1:0]   len_reg;
    logic                         loop_reg;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t                         state_reg;
    logic [svrm_pkg::POS_W-1:0]     pos_reg;
    logic [svrm_pkg::PHASE_W-1:0]   phase_reg;
    logic                           out_valid_reg;
    svrm_pkg::svrm_out_t            out_data_reg;

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic [15:0]                        store_mem [STORE_WORDS];
    logic [15:0]                        rd_data_reg;
    logic                               oob_l_reg;
    logic                               oob_r_reg;
    logic [svrm_pkg::RATE_W+svrm_pkg::SCALE_W-1:0] rate_prod_reg;
    logic [svrm_pkg::PE_W-1:0]          pe_reg;
    logic signed [24:0]                 mul_reg;
    logic signed [15:0]                 res_left_reg;
    logic signed [15:0]                 res_right_reg;
    logic                               res_done_reg;

    // ------------------------------------------------------------------
    // combinational signals
    // ------------------------------------------------------------------
    logic                           in_accept;
    logic                           at_end;
    logic                           mix_wrap;
    logic [svrm_pkg::POS_W-1:0]     pos_eff;
    logic [svrm_pkg::PHASE_W-1:0]   phase_eff;
    logic                           eff_end;
    logic [svrm_pkg::POS_W:0]       pos_r;
    logic                           oob_l;
    logic                           oob_r;
    logic                           wr_ok;
    logic                           mem_we;
    logic [EXT_W-1:0]               addr_ext;
    logic [AW-1:0]                  mem_addr;
    logic                           done_at_accept;
    logic                           oob_sel;
    logic signed [15:0]             vol_word;
    logic signed [8:0]              vol_s;
    logic signed [24:0]             vol_prod;
    logic [svrm_pkg::RATE_W-1:0]    orate_eff;
    logic                           pe_carry;
    logic                           div_start;
    logic [svrm_pkg::PE_W-1:0]      div_dividend;
    logic                           div_done;
    logic [svrm_pkg::PE_W-1:0]      div_q;
    logic [svrm_pkg::PHASE_W-1:0]   div_r;
    logic [svrm_pkg::PE_W:0]        div_shift;
    logic [SUM_W-1:0]               pos_sum;
    logic [svrm_pkg::POS_W-1:0]     pos_sat;
    logic                           carry_wrap;

    // Add the scaled sample (product >> 7, floor) to the bus value, clamp to 16 bits.
    function automatic logic signed [15:0] mix_sat(input logic signed [15:0] bus,
                                                   input logic signed [24:0] prod);
        logic signed [18:0] sum;
        sum = 19'(bus) + 19'($signed(prod[24:7]));
        if (sum > 19'sd32767)
            return 16'sh7fff;
        else if (sum < -19'sd32768)
            return 16'sh8000;
        else
            return sum[15:0];
    endfunction

    // ------------------------------------------------------------------
    // handshake: one item in flight; the output register parts the sides
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // position bookkeeping at accept
    // ------------------------------------------------------------------
    always_comb
    begin
        at_end    = (pos_reg >= len_reg);
        // a looping voice found at the end restarts before it mixes
        mix_wrap  = at_end && loop_reg;
        pos_eff   = mix_wrap ? '0 : pos_reg;
        phase_eff = mix_wrap ? '0 : phase_reg;
        eff_end   = (pos_eff >= len_reg);
        // right word: same word when mono, next word when stereo
        pos_r     = {1'b0, pos_reg} + {{svrm_pkg::POS_W{1'b0}}, stereo_reg};
        // words beyond the store read as zero; writes beyond it are dropped
        oob_l     = (32'(pos_eff) >= 32'(STORE_WORDS));
        oob_r     = (32'(pos_r) >= 32'(STORE_WORDS));
        wr_ok     = (32'(in_data.sample_address) < 32'(STORE_WORDS));
        mem_we    = in_accept && (in_data.mode == svrm_pkg::MODE_WRITE) && wr_ok;

        case (in_data.mode)
            svrm_pkg::MODE_WRITE:   done_at_accept = at_end;
            svrm_pkg::MODE_MIX:     done_at_accept = eff_end;
            svrm_pkg::MODE_RESTART: done_at_accept = (len_reg == '0);
            default:                done_at_accept = at_end;
        endcase
    end

    // ------------------------------------------------------------------
    // sample store port: write or left read in IDLE, right read in RD_R
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_RD_R:  addr_ext = EXT_W'(pos_r);
            default:
            begin
                if (in_data.mode == svrm_pkg::MODE_WRITE)
                    addr_ext = EXT_W'(in_data.sample_address);
                else
                    addr_ext = EXT_W'(pos_eff);
            end
        endcase
        mem_addr = addr_ext[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= in_data.sample_value;
        rd_data_reg <= store_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // volume multiplier, shared by left (RD_R) and right (MIX)
    // ------------------------------------------------------------------
    always_comb
    begin
        oob_sel  = (state_reg == S_RD_R) ? oob_l_reg : oob_r_reg;
        vol_word = oob_sel ? 16'sd0 : $signed(rd_data_reg);
        vol_s    = $signed({1'b0, vol_reg});
        vol_prod = vol_word * vol_s;
    end

    // ------------------------------------------------------------------
    // phase advance and carry into the read position
    // ------------------------------------------------------------------
    always_comb
    begin
        // zero output rate counts as one
        orate_eff    = (orate_reg == '0) ? svrm_pkg::RATE_W'(1) : orate_reg;
        pe_carry     = (pe_reg > svrm_pkg::PE_W'(orate_eff));
        div_start    = (state_reg == S_SAT) && pe_carry;
        div_dividend = pe_reg - svrm_pkg::PE_W'(1);

        // frames advanced times channels, saturated to the position range
        div_shift  = stereo_reg ? {div_q, 1'b0} : {1'b0, div_q};
        pos_sum    = SUM_W'(pos_reg) + SUM_W'(div_shift);
        pos_sat    = (pos_sum > SUM_W'(svrm_pkg::POS_MAX)) ? svrm_pkg::POS_MAX
                                                            : pos_sum[svrm_pkg::POS_W-1:0];
        // a looping voice wraps as soon as the advance reaches the end
        carry_wrap = (pos_sat >= len_reg) && loop_reg;
    end

    svrm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (orate_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg    <= svrm_pkg::VOLUME_RST;
            src_reg    <= svrm_pkg::SOURCE_RATE_RST;
            scale_reg  <= svrm_pkg::RATE_SCALE_RST;
            orate_reg  <= svrm_pkg::OUTPUT_RATE_RST;
            stereo_reg <= 1'b0;
            len_reg    <= '0;
            loop_reg   <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                svrm_pkg::CFG_VOLUME:        vol_reg    <= cfg_data[svrm_pkg::VOL_W-1:0];
                svrm_pkg::CFG_SOURCE_RATE:   src_reg    <= cfg_data[svrm_pkg::RATE_W-1:0];
                svrm_pkg::CFG_RATE_SCALE:    scale_reg  <= cfg_data[svrm_pkg::SCALE_W-1:0];
                svrm_pkg::CFG_OUTPUT_RATE:   orate_reg  <= cfg_data[svrm_pkg::RATE_W-1:0];
                svrm_pkg::CFG_STEREO:        stereo_reg <= cfg_data[0];
                svrm_pkg::CFG_SAMPLE_LENGTH: len_reg    <= cfg_data[svrm_pkg::LEN_W-1:0];
                svrm_pkg::CFG_LOOP_ENABLE:   loop_reg   <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer: state, position, phase and the output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // drop the result once the transaction completes
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (in_data.mode)
                            svrm_pkg::MODE_RESTART:
                            begin
                                pos_reg   <= '0;
                                phase_reg <= '0;
                                state_reg <= S_PUSH;
                            end
                            svrm_pkg::MODE_MIX:
                            begin
                                pos_reg   <= pos_eff;
                                phase_reg <= phase_eff;
                                state_reg <= eff_end ? S_PUSH : S_RD_R;
                            end
                            default: state_reg <= S_PUSH;
                        endcase
                    end
                end
                S_RD_R: state_reg <= S_MIX;
                S_MIX:  state_reg <= S_SAT;
                S_SAT:
                begin
                    // a carry past the output rate goes to DIV; else hold position, store the new phase
                    if (pe_carry)
                        state_reg <= S_DIV;
                    else
                    begin
                        phase_reg <= pe_reg[svrm_pkg::PHASE_W-1:0];
                        state_reg <= S_PUSH;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pos_reg   <= carry_wrap ? '0 : pos_sat;
                        phase_reg <= carry_wrap ? '0 : div_r + 1'b1;
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_data_reg.mixed_left  <= res_left_reg;
                        out_data_reg.mixed_right <= res_right_reg;
                        out_data_reg.voice_done  <= res_done_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath: bus values pass through unless a sample is mixed in
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_left_reg  <= in_data.bus_left;
            res_right_reg <= in_data.bus_right;
            res_done_reg  <= done_at_accept;
            oob_l_reg     <= oob_l;
            rate_prod_reg <= (svrm_pkg::RATE_W + svrm_pkg::SCALE_W)'(src_reg)
                           * (svrm_pkg::RATE_W + svrm_pkg::SCALE_W)'(scale_reg);
        end

        case (state_reg)
            S_RD_R:
            begin
                mul_reg   <= vol_prod;
                oob_r_reg <= oob_r;
                pe_reg    <= svrm_pkg::PE_W'(phase_reg)
                           + svrm_pkg::PE_W'(rate_prod_reg[svrm_pkg::RATE_W+svrm_pkg::SCALE_W-1:8]);
            end
            S_MIX:
            begin
                res_left_reg <= mix_sat(res_left_reg, mul_reg);
                mul_reg      <= vol_prod;
            end
            S_SAT:
            begin
                res_right_reg <= mix_sat(res_right_reg, mul_reg);
            end
            default: ;
        endcase
    end

endmodule
